>>> hdl/assert_macros.svh
// Assertion macros shared by the formatter RTL.
// Every macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DFMT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DFMT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/dfmt_pkg.sv
// Package of the decimal field formatter: digit and item types, character codes,
// and the constant-divisor helpers. No dependencies.
package dfmt_pkg;

    localparam int unsigned DIGITS = 5;

    localparam logic [2:0] POS_LAST = 3'd4;
    localparam logic [2:0] WIDTH_MAX = 3'd5;

    localparam logic [5:0] CHAR_SPACE = 6'd32;
    localparam logic [5:0] CHAR_ZERO = 6'd48;
    localparam logic [5:0] CHAR_NINE = 6'd57;

    localparam logic [15:0] PLACE_10000 = 16'd10000;
    localparam logic [15:0] PLACE_1000 = 16'd1000;
    localparam logic [15:0] PLACE_100 = 16'd100;
    localparam logic [15:0] PLACE_10 = 16'd10;

    // floor(2^22 / 100); the quotient it gives may be one low and is corrected.
    localparam logic [15:0] RECIP_100_Q22 = 16'd41943;
    // Exact quotient by 100 for values below 656 after a shift by 12.
    localparam logic [15:0] RECIP_100_Q12 = 16'd41;
    // Exact quotient by 10 for values below 100 after a shift by 11.
    localparam logic [14:0] RECIP_10_Q11 = 15'd205;

    typedef logic [3:0] t_digit;

    typedef struct packed {
        t_digit [DIGITS-1:0] digits;
        logic [2:0] first_sig;
        logic [2:0] start_pos;
    } t_item;

    typedef struct packed {
        t_digit quot;
        t_digit rem;
    } t_div10;

    function automatic t_div10 div10(input logic [6:0] n);
        logic [14:0] prod;
        logic [6:0] back;
        logic [6:0] diff;
        t_div10 res;
        prod = {8'd0, n} * RECIP_10_Q11;
        res.quot = prod[14:11];
        back = {3'd0, res.quot} * 7'd10;
        diff = n - back;
        res.rem = diff[3:0];
        return res;
    endfunction

endpackage

>>> hdl/dfmt_bcd.sv
// Binary to decimal digit pipeline: input register and three short stages.
// Depends on dfmt_pkg for the item type and the constant-divisor helpers.
module dfmt_bcd (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [15:0]          i_value,
    input  logic [2:0]           i_field_width,
    input  logic                 i_take,
    output logic                 o_ready,
    output logic                 o_valid,
    output dfmt_pkg::t_item      o_item
);

    logic r_s0_vld, r_s1_vld, r_s2_vld, r_s3_vld;
    logic n_s0_vld, n_s1_vld, n_s2_vld, n_s3_vld;
    logic en0, en1, en2, en3;

    logic [15:0] r_s0_value;
    logic [2:0]  r_s0_first, r_s0_start;
    logic [9:0]  r_s1_hi;
    logic [6:0]  r_s1_lo;
    logic [2:0]  r_s1_first, r_s1_start;
    dfmt_pkg::t_digit r_s2_d4, r_s2_d1, r_s2_d0;
    logic [6:0]  r_s2_mid;
    logic [2:0]  r_s2_first, r_s2_start;
    dfmt_pkg::t_item r_s3_item;

    logic [2:0] n_first, n_start, wclamp, wstart;
    logic [31:0] p100;
    logic [9:0]  q0;
    logic [16:0] q0x100, rraw, rfix;
    logic [9:0]  n_hi;
    logic [6:0]  n_lo;
    logic [15:0] p4;
    dfmt_pkg::t_digit n_d4;
    logic [9:0]  h100, mid10;
    dfmt_pkg::t_div10 dlo, dmid;
    dfmt_pkg::t_item n_item;

    assign en3 = !r_s3_vld || i_take;
    assign en2 = !r_s2_vld || en3;
    assign en1 = !r_s1_vld || en2;
    assign en0 = !r_s0_vld || en1;
    assign o_ready = en0;
    assign o_valid = r_s3_vld;
    assign o_item = r_s3_item;

    always_comb begin
        n_s0_vld = en0 ? i_accept : r_s0_vld;
        n_s1_vld = en1 ? r_s0_vld : r_s1_vld;
        n_s2_vld = en2 ? r_s1_vld : r_s2_vld;
        n_s3_vld = en3 ? r_s2_vld : r_s3_vld;
    end

    always_comb begin
        if (i_value >= dfmt_pkg::PLACE_10000) begin
            n_first = 3'd0;
        end else if (i_value >= dfmt_pkg::PLACE_1000) begin
            n_first = 3'd1;
        end else if (i_value >= dfmt_pkg::PLACE_100) begin
            n_first = 3'd2;
        end else if (i_value >= dfmt_pkg::PLACE_10) begin
            n_first = 3'd3;
        end else begin
            n_first = 3'd4;
        end
        if (i_field_width > dfmt_pkg::WIDTH_MAX) begin
            wclamp = dfmt_pkg::WIDTH_MAX;
        end else if (i_field_width == 3'd0) begin
            wclamp = 3'd1;
        end else begin
            wclamp = i_field_width;
        end
        wstart = dfmt_pkg::WIDTH_MAX - wclamp;
        n_start = (wstart < n_first) ? wstart : n_first;
    end

    always_comb begin
        p100 = {16'd0, r_s0_value} * {16'd0, dfmt_pkg::RECIP_100_Q22};
        q0 = p100[31:22];
        q0x100 = {7'd0, q0} * 17'd100;
        rraw = {1'b0, r_s0_value} - q0x100;
        if (rraw >= 17'd100) begin
            rfix = rraw - 17'd100;
            n_hi = q0 + 10'd1;
        end else begin
            rfix = rraw;
            n_hi = q0;
        end
        n_lo = rfix[6:0];
    end

    always_comb begin
        p4 = {6'd0, r_s1_hi} * dfmt_pkg::RECIP_100_Q12;
        n_d4 = p4[15:12];
        h100 = {6'd0, n_d4} * 10'd100;
        mid10 = r_s1_hi - h100;
        dlo = dfmt_pkg::div10(r_s1_lo);
    end

    always_comb begin
        dmid = dfmt_pkg::div10(r_s2_mid);
        n_item.digits[0] = r_s2_d4;
        n_item.digits[1] = dmid.quot;
        n_item.digits[2] = dmid.rem;
        n_item.digits[3] = r_s2_d1;
        n_item.digits[4] = r_s2_d0;
        n_item.first_sig = r_s2_first;
        n_item.start_pos = r_s2_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s0_vld <= n_s0_vld;
            r_s1_vld <= n_s1_vld;
            r_s2_vld <= n_s2_vld;
            r_s3_vld <= n_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0 && i_accept) begin
            r_s0_value <= i_value;
            r_s0_first <= n_first;
            r_s0_start <= n_start;
        end
        if (en1) begin
            r_s1_hi <= n_hi;
            r_s1_lo <= n_lo;
            r_s1_first <= r_s0_first;
            r_s1_start <= r_s0_start;
        end
        if (en2) begin
            r_s2_d4 <= n_d4;
            r_s2_mid <= mid10[6:0];
            r_s2_d1 <= dlo.quot;
            r_s2_d0 <= dlo.rem;
            r_s2_first <= r_s1_first;
            r_s2_start <= r_s1_start;
        end
        if (en3) begin
            r_s3_item <= n_item;
        end
    end

endmodule

>>> hdl/dfmt_ser.sv
// Character serializer: walks the digit positions of one item, one character per cycle,
// into a registered result stage. Depends on dfmt_pkg for the item type and codes.
module dfmt_ser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  dfmt_pkg::t_item      i_item,
    output logic                 o_take,
    output logic                 o_strobe,
    output logic [5:0]           o_character,
    output logic                 o_last
);

    logic r_act, n_act;
    logic [2:0] r_pos, n_pos;
    logic [2:0] r_first;
    dfmt_pkg::t_digit [dfmt_pkg::DIGITS-1:0] r_digits;
    logic r_out_vld;
    logic [5:0] r_char, n_char;
    logic r_last, n_last;

    assign o_take = i_valid && (!r_act || (r_pos == dfmt_pkg::POS_LAST));
    assign o_strobe = r_out_vld;
    assign o_character = r_char;
    assign o_last = r_last;

    always_comb begin
        if (o_take) begin
            n_act = 1'b1;
            n_pos = i_item.start_pos;
        end else if (r_act && (r_pos == dfmt_pkg::POS_LAST)) begin
            n_act = 1'b0;
            n_pos = r_pos;
        end else if (r_act) begin
            n_act = 1'b1;
            n_pos = r_pos + 3'd1;
        end else begin
            n_act = 1'b0;
            n_pos = r_pos;
        end
    end

    always_comb begin
        if (r_pos >= r_first) begin
            n_char = dfmt_pkg::CHAR_ZERO + {2'd0, r_digits[r_pos]};
        end else begin
            n_char = dfmt_pkg::CHAR_SPACE;
        end
        n_last = (r_pos == dfmt_pkg::POS_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_act <= n_act;
            r_out_vld <= r_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_char <= n_char;
        r_last <= n_last;
        if (o_take) begin
            r_first <= i_item.first_sig;
            r_digits <= i_item.digits;
        end
    end

endmodule

>>> hdl/decimal_field_formatter_core.sv
// Top level of the decimal field formatter: digit pipeline feeding the character serializer.
// Depends on dfmt_pkg, dfmt_bcd, dfmt_ser and assert_macros.svh.
//
// Channel   Direction  Handshake              Payload
// number    in         start high, busy low   i_value[15:0], i_field_width[2:0]
// char      out        o_strobe, one cycle    o_character[5:0], o_last
//
// A number turns into max(digits, clamped width) characters, one per cycle, so the
// sustained number rate is set by the one-character-per-cycle serializer. The first character
// passes the digit pipeline and the serializer's position and result registers; a new number may be
// transferred every cycle until the four-deep digit pipeline fills behind a running number.
// busy rises only while that pipeline is full; the receiver takes every character.
// Synchronous reset clears the valid bits only.
`include "assert_macros.svh"

module decimal_field_formatter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_value,
    input  logic [2:0]  i_field_width,
    output logic        o_strobe,
    output logic [5:0]  o_character,
    output logic        o_last
);

    logic ready;
    logic item_vld;
    logic take;
    dfmt_pkg::t_item item;
    logic is_space;
    logic is_digit;

    assign busy = !ready;
    assign is_space = (o_character == dfmt_pkg::CHAR_SPACE);
    assign is_digit = (o_character >= dfmt_pkg::CHAR_ZERO) &&
                      (o_character <= dfmt_pkg::CHAR_NINE);

    dfmt_bcd u_bcd (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (start),
        .i_value       (i_value),
        .i_field_width (i_field_width),
        .i_take        (take),
        .o_ready       (ready),
        .o_valid       (item_vld),
        .o_item        (item)
    );

    dfmt_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (item_vld),
        .i_item      (item),
        .o_take      (take),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

    `DFMT_ASSERT_NXT(a_run_contiguous, o_strobe && !o_last, o_strobe, "character run broken")
    `DFMT_ASSERT_NXT(a_digit_then_digit, o_strobe && !o_last && !is_space, !is_space, "space after a digit")
    `DFMT_ASSERT_IMP(a_last_is_digit, o_strobe && o_last, is_digit, "run ends without a digit")
    `DFMT_ASSERT_IMP(a_char_code, o_strobe, is_space || is_digit, "bad character code")

endmodule
